// ===== rtl/pfx_pkg.sv =====
// Shared types, character codes, error codes and helpers for the postfix evaluator.
// No dependencies; used by pfx_ram users, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package pfx_pkg;

    localparam int VAL_W  = 48;
    localparam int FD_W   = 4;
    localparam int ERR_W  = 3;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MOD   = 8'h25;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
    localparam logic [ERR_W-1:0] ERR_CHAR = 3'd1;
    localparam logic [ERR_W-1:0] ERR_FRAC = 3'd2;
    localparam logic [ERR_W-1:0] ERR_FEW  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_FULL = 3'd4;
    localparam logic [ERR_W-1:0] ERR_DIV0 = 3'd5;

    localparam logic [VAL_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 48'h8000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_NUMLD, ST_DIV, ST_DIVRES, ST_OPCHK, ST_OPRB,
        ST_OPRA, ST_OPGO, ST_OPEX, ST_MUL, ST_MULRES, ST_PUSH, ST_FINCHK,
        ST_ENDRD, ST_ENDWT, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        JOB_NUM, JOB_DIV, JOB_MOD
    } job_t;

    // Power of ten for a fraction digit count.
    function automatic logic [VAL_W-1:0] pow10(input logic [FD_W-1:0] n);
        logic [VAL_W-1:0] p;
        unique case (n)
            4'd0:    p = 48'd1;
            4'd1:    p = 48'd10;
            4'd2:    p = 48'd100;
            4'd3:    p = 48'd1000;
            4'd4:    p = 48'd10000;
            4'd5:    p = 48'd100000;
            4'd6:    p = 48'd1000000;
            4'd7:    p = 48'd10000000;
            4'd8:    p = 48'd100000000;
            default: p = 48'd1000000000;
        endcase
        return p;
    endfunction

    // Apply sign to a magnitude and clamp to the signed 48-bit range.
    function automatic logic [VAL_W-1:0] sat_mag(input logic [VAL_W-1:0] mag,
                                                 input logic over, input logic neg);
        logic [VAL_W-1:0] r;
        if (neg) begin
            r = (over || mag[VAL_W-1]) ? VAL_MIN : (~mag + 48'd1);
        end else begin
            r = (over || mag[VAL_W-1]) ? VAL_MAX : mag;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/postfix_expression_evaluator_top.sv =====
// Postfix expression evaluator: character decoder, value stack and sequencer
// around one shared add/subtract unit. Depends on pfx_pkg and pfx_ram.
//
//  channel | ports                               | role
//  s_      | s_valid s_ready s_char_code s_last  | one expression character
//  m_      | m_valid m_ready m_value m_error     | value and error at end
//
// A digit, point or space that ends nothing passes through decode and the
// end-of-item check; a number end runs the shared unit as a restoring divider;
// '*' runs it as a shift-add multiplier; '/' and '%' run the divider again.
// The last character adds a stack read of the top value before the output.
// Reset is synchronous; the stack RAM is not cleared. A stalled result holds
// in the output register and the block finishes the next expression only
// after it is taken.
`timescale 1ns / 1ps
`default_nettype none
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH         = 16,
    parameter int FRACTION_BITS       = 16,
    parameter int MAX_FRACTION_DIGITS = 6
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [pfx_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic                        s_last,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [pfx_pkg::VAL_W-1:0] m_value,
    output logic [pfx_pkg::ERR_W-1:0]        m_error
);
    localparam int VW  = pfx_pkg::VAL_W;
    localparam int DW  = VW + FRACTION_BITS;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int KW  = $clog2(DW);
    localparam int AUW = VW + 2;

    pfx_pkg::state_t state_reg, state_next;
    pfx_pkg::job_t   job_reg, job_next;

    logic [pfx_pkg::CHAR_W-1:0] c_reg, c_next;
    logic                       fin_reg, fin_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [VW-1:0]              mant_reg, mant_next;
    logic [pfx_pkg::FD_W-1:0]   fd_reg, fd_next;
    logic                       innum_reg, innum_next;
    logic                       seen_reg, seen_next;
    logic [pfx_pkg::ERR_W-1:0]  sticky_reg, sticky_next;
    logic                       oppend_reg, oppend_next;
    logic                       neg_reg, neg_next;
    logic [VW-1:0]              a_reg, a_next;
    logic [VW-1:0]              b_reg, b_next;
    logic [VW-1:0]              res_reg, res_next;
    logic [DW-1:0]              dvd_reg, dvd_next;
    logic [VW-1:0]              rem_reg, rem_next;
    logic [VW-1:0]              dvs_reg, dvs_next;
    logic [KW-1:0]              k_reg, k_next;
    logic                       mvalid_reg, mvalid_next;
    logic [VW-1:0]              mvalue_reg, mvalue_next;
    logic [pfx_pkg::ERR_W-1:0]  merror_reg, merror_next;

    // shared adder
    logic [AUW-1:0] add_a, add_b, add_sum;
    logic           add_sub;

    // stack RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_rdata;

    logic [CW-1:0]      cnt_m1, cnt_m2;
    logic [VW+3:0]      mant_x10;
    logic [VW:0]        trial;
    logic [VW:0]        mul_sum;
    logic [2*VW-1:0]    mul_prod;
    logic [VW-1:0]      mag_a, mag_b;
    logic [VW:0]        sum49;
    logic               is_digit, is_op;

    pfx_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (res_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == pfx_pkg::ST_IDLE);
    assign m_valid = mvalid_reg;
    assign m_value = mvalue_reg;
    assign m_error = merror_reg;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign mul_prod = {rem_reg, dvd_reg[VW-1:0]};
    assign mag_a    = a_reg[VW-1] ? (~a_reg + VW'(1)) : a_reg;
    assign mag_b    = b_reg[VW-1] ? (~b_reg + VW'(1)) : b_reg;
    assign mant_x10 = {1'b0, mant_reg, 3'b000} + {3'b000, mant_reg, 1'b0}
                      + (VW+4)'(c_reg - pfx_pkg::CH_ZERO);
    assign is_digit = (c_reg >= pfx_pkg::CH_ZERO) && (c_reg <= pfx_pkg::CH_NINE);
    assign is_op    = (c_reg == pfx_pkg::CH_ADD) || (c_reg == pfx_pkg::CH_SUB)
                   || (c_reg == pfx_pkg::CH_MUL) || (c_reg == pfx_pkg::CH_DIV)
                   || (c_reg == pfx_pkg::CH_MOD);
    assign add_sum  = add_a + (add_sub ? ~add_b : add_b) + AUW'(add_sub);
    assign mul_sum  = dvd_reg[0] ? add_sum[VW:0] : {1'b0, rem_reg};
    assign sum49    = add_sum[VW:0];

    // Shared adder operand select
    always_comb begin
        add_a   = {2'b00, rem_reg};
        add_b   = {2'b00, dvs_reg};
        add_sub = 1'b0;
        if (state_reg == pfx_pkg::ST_DIV) begin
            add_a   = {1'b0, trial};
            add_sub = 1'b1;
        end else if (state_reg == pfx_pkg::ST_OPEX) begin
            add_a   = {{2{a_reg[VW-1]}}, a_reg};
            add_b   = {{2{b_reg[VW-1]}}, b_reg};
            add_sub = (c_reg == pfx_pkg::CH_SUB);
        end
    end

    // Sequencer: next state and datapath
    always_comb begin
        state_next  = state_reg;
        job_next    = job_reg;
        c_next      = c_reg;
        fin_next    = fin_reg;
        count_next  = count_reg;
        mant_next   = mant_reg;
        fd_next     = fd_reg;
        innum_next  = innum_reg;
        seen_next   = seen_reg;
        sticky_next = sticky_reg;
        oppend_next = oppend_reg;
        neg_next    = neg_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        res_next    = res_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        k_next      = k_reg;
        mvalid_next = mvalid_reg && !m_ready;
        mvalue_next = mvalue_reg;
        merror_next = merror_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_raddr   = cnt_m1[AW-1:0];

        unique case (state_reg)
            pfx_pkg::ST_IDLE: begin
                if (s_valid) begin
                    c_next     = s_char_code;
                    fin_next   = s_last;
                    state_next = pfx_pkg::ST_DECODE;
                end
            end
            pfx_pkg::ST_DECODE: begin
                state_next = pfx_pkg::ST_FINCHK;
                if (sticky_reg == pfx_pkg::ERR_NONE) begin
                    if (is_digit) begin
                        innum_next = 1'b1;
                        if (!(seen_reg && fd_reg >= pfx_pkg::FD_W'(MAX_FRACTION_DIGITS))) begin
                            if (seen_reg) begin
                                fd_next = fd_reg + 4'd1;
                            end
                            mant_next = (mant_x10[VW+3:VW] != 4'd0) ? {VW{1'b1}}
                                                                      : mant_x10[VW-1:0];
                        end
                    end else if (c_reg == pfx_pkg::CH_POINT || c_reg == pfx_pkg::CH_COMMA) begin
                        if (seen_reg) begin
                            sticky_next = pfx_pkg::ERR_CHAR;
                        end else begin
                            seen_next  = 1'b1;
                            innum_next = 1'b1;
                        end
                    end else if (c_reg == pfx_pkg::CH_SPACE) begin
                        if (innum_reg) begin
                            state_next = pfx_pkg::ST_NUMLD;
                        end
                    end else if (is_op) begin
                        if (innum_reg) begin
                            oppend_next = 1'b1;
                            state_next  = pfx_pkg::ST_NUMLD;
                        end else begin
                            state_next = pfx_pkg::ST_OPCHK;
                        end
                    end else begin
                        sticky_next = pfx_pkg::ERR_CHAR;
                    end
                end
            end
            // Convert the number: (mantissa << FB) / 10^digits
            pfx_pkg::ST_NUMLD: begin
                dvd_next   = {mant_reg, {FRACTION_BITS{1'b0}}};
                dvs_next   = pfx_pkg::pow10(fd_reg);
                rem_next   = '0;
                k_next     = KW'(DW - 1);
                job_next   = pfx_pkg::JOB_NUM;
                neg_next   = 1'b0;
                mant_next  = '0;
                fd_next    = '0;
                innum_next = 1'b0;
                seen_next  = 1'b0;
                state_next = pfx_pkg::ST_DIV;
            end
            // One quotient bit per cycle
            pfx_pkg::ST_DIV: begin
                if (!add_sum[AUW-1]) begin
                    rem_next = add_sum[VW-1:0];
                end else begin
                    rem_next = trial[VW-1:0];
                end
                dvd_next = {dvd_reg[DW-2:0], !add_sum[AUW-1]};
                k_next   = k_reg - KW'(1);
                if (k_reg == '0) begin
                    state_next = pfx_pkg::ST_DIVRES;
                end
            end
            pfx_pkg::ST_DIVRES: begin
                if (job_reg == pfx_pkg::JOB_MOD) begin
                    res_next = pfx_pkg::sat_mag(rem_reg, 1'b0, neg_reg);
                end else begin
                    res_next = pfx_pkg::sat_mag(dvd_reg[VW-1:0], |dvd_reg[DW-1:VW], neg_reg);
                end
                state_next = pfx_pkg::ST_PUSH;
            end
            pfx_pkg::ST_OPCHK: begin
                oppend_next = 1'b0;
                if (sticky_reg != pfx_pkg::ERR_NONE) begin
                    state_next = pfx_pkg::ST_FINCHK;
                end else if (count_reg < CW'(2)) begin
                    sticky_next = pfx_pkg::ERR_FEW;
                    state_next  = pfx_pkg::ST_FINCHK;
                end else begin
                    state_next = pfx_pkg::ST_OPRB;
                end
            end
            pfx_pkg::ST_OPRB: begin
                state_next = pfx_pkg::ST_OPRA;
            end
            pfx_pkg::ST_OPRA: begin
                b_next     = ram_rdata;
                ram_raddr  = cnt_m2[AW-1:0];
                state_next = pfx_pkg::ST_OPGO;
            end
            pfx_pkg::ST_OPGO: begin
                a_next     = ram_rdata;
                count_next = cnt_m2;
                state_next = pfx_pkg::ST_OPEX;
            end
            // Dispatch the operator
            pfx_pkg::ST_OPEX: begin
                rem_next = '0;
                dvs_next = mag_b;
                priority if (c_reg == pfx_pkg::CH_ADD || c_reg == pfx_pkg::CH_SUB) begin
                    if (sum49[VW] != sum49[VW-1]) begin
                        res_next = sum49[VW] ? pfx_pkg::VAL_MIN : pfx_pkg::VAL_MAX;
                    end else begin
                        res_next = sum49[VW-1:0];
                    end
                    state_next = pfx_pkg::ST_PUSH;
                end else if (c_reg == pfx_pkg::CH_MUL) begin
                    dvd_next   = {{FRACTION_BITS{1'b0}}, mag_a};
                    neg_next   = a_reg[VW-1] ^ b_reg[VW-1];
                    k_next     = KW'(VW - 1);
                    state_next = pfx_pkg::ST_MUL;
                end else if (c_reg == pfx_pkg::CH_DIV) begin
                    if (b_reg == '0) begin
                        sticky_next = pfx_pkg::ERR_DIV0;
                        state_next  = pfx_pkg::ST_FINCHK;
                    end else begin
                        dvd_next   = {mag_a, {FRACTION_BITS{1'b0}}};
                        neg_next   = a_reg[VW-1] ^ b_reg[VW-1];
                        k_next     = KW'(DW - 1);
                        job_next   = pfx_pkg::JOB_DIV;
                        state_next = pfx_pkg::ST_DIV;
                    end
                end else begin
                    if (a_reg[FRACTION_BITS-1:0] != '0 || b_reg[FRACTION_BITS-1:0] != '0) begin
                        sticky_next = pfx_pkg::ERR_FRAC;
                        state_next  = pfx_pkg::ST_FINCHK;
                    end else if (b_reg == '0) begin
                        sticky_next = pfx_pkg::ERR_DIV0;
                        state_next  = pfx_pkg::ST_FINCHK;
                    end else begin
                        dvd_next   = {{FRACTION_BITS{1'b0}}, mag_a};
                        neg_next   = a_reg[VW-1];
                        k_next     = KW'(DW - 1);
                        job_next   = pfx_pkg::JOB_MOD;
                        state_next = pfx_pkg::ST_DIV;
                    end
                end
            end
            // Shift-add multiply, one multiplier bit per cycle
            pfx_pkg::ST_MUL: begin
                rem_next            = mul_sum[VW:1];
                dvd_next[VW-1:0]    = {mul_sum[0], dvd_reg[VW-1:1]};
                k_next              = k_reg - KW'(1);
                if (k_reg == '0) begin
                    state_next = pfx_pkg::ST_MULRES;
                end
            end
            pfx_pkg::ST_MULRES: begin
                res_next   = pfx_pkg::sat_mag(mul_prod[FRACTION_BITS+VW-1:FRACTION_BITS],
                                              |mul_prod[2*VW-1:FRACTION_BITS+VW], neg_reg);
                state_next = pfx_pkg::ST_PUSH;
            end
            pfx_pkg::ST_PUSH: begin
                if (count_reg >= CW'(STACK_DEPTH)) begin
                    if (sticky_reg == pfx_pkg::ERR_NONE) begin
                        sticky_next = pfx_pkg::ERR_FULL;
                    end
                end else begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                state_next = oppend_reg ? pfx_pkg::ST_OPCHK : pfx_pkg::ST_FINCHK;
            end
            // End of item: finish the expression on the last character
            pfx_pkg::ST_FINCHK: begin
                if (!fin_reg) begin
                    state_next = pfx_pkg::ST_IDLE;
                end else if (sticky_reg == pfx_pkg::ERR_NONE && innum_reg) begin
                    state_next = pfx_pkg::ST_NUMLD;
                end else if (sticky_reg != pfx_pkg::ERR_NONE || count_reg == '0) begin
                    state_next = pfx_pkg::ST_OUT;
                end else begin
                    state_next = pfx_pkg::ST_ENDRD;
                end
            end
            pfx_pkg::ST_ENDRD: begin
                state_next = pfx_pkg::ST_ENDWT;
            end
            pfx_pkg::ST_ENDWT: begin
                res_next   = ram_rdata;
                state_next = pfx_pkg::ST_OUT;
            end
            pfx_pkg::ST_OUT: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    if (sticky_reg != pfx_pkg::ERR_NONE) begin
                        merror_next = sticky_reg;
                        mvalue_next = '0;
                    end else if (count_reg == '0) begin
                        merror_next = pfx_pkg::ERR_FEW;
                        mvalue_next = '0;
                    end else begin
                        merror_next = pfx_pkg::ERR_NONE;
                        mvalue_next = res_reg;
                    end
                    count_next  = '0;
                    mant_next   = '0;
                    fd_next     = '0;
                    innum_next  = 1'b0;
                    seen_next   = 1'b0;
                    sticky_next = pfx_pkg::ERR_NONE;
                    oppend_next = 1'b0;
                    state_next  = pfx_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfx_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pfx_pkg::ST_IDLE;
            count_reg  <= '0;
            mant_reg   <= '0;
            fd_reg     <= '0;
            innum_reg  <= 1'b0;
            seen_reg   <= 1'b0;
            sticky_reg <= pfx_pkg::ERR_NONE;
            oppend_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mant_reg   <= mant_next;
            fd_reg     <= fd_next;
            innum_reg  <= innum_next;
            seen_reg   <= seen_next;
            sticky_reg <= sticky_next;
            oppend_reg <= oppend_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        c_reg      <= c_next;
        fin_reg    <= fin_next;
        neg_reg    <= neg_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        res_reg    <= res_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        k_reg      <= k_next;
        mvalue_reg <= mvalue_next;
        merror_reg <= merror_next;
    end

endmodule
`default_nettype wire

// ===== rtl/pfx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pfx_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/pfx_checker.sv =====
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on pfx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfx_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [pfx_pkg::VAL_W-1:0]  m_value,
    input wire logic [pfx_pkg::ERR_W-1:0]  m_error
);
    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_error))
        else $error("result changed while stalled");

    // An error result carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error != pfx_pkg::ERR_NONE |-> m_value == '0)
        else $error("nonzero value with error");

    // Error code stays within the defined set
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_error <= pfx_pkg::ERR_DIV0)
        else $error("undefined error code");

    // No result right out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A new character is never taken in the cycle right after one is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");
endmodule

bind postfix_expression_evaluator_top pfx_checker u_pfx_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value),
    .m_error (m_error)
);
`default_nettype wire
